// ===== hw/rtl/gwm_pkg.sv =====
// Shared types and constants for the glob wildcard matcher.
// Used by gwm_cell and glob_wildcard_matcher; depends on nothing else.
`timescale 1ns / 1ps

package gwm_pkg;

  typedef enum logic [1:0] {
    FUNC_PATTERN = 2'd0,
    FUNC_TEXT    = 2'd1,
    FUNC_FINISH  = 2'd2,
    FUNC_NOP     = 2'd3
  } func_t;

  localparam logic [7:0] CH_ANY  = 8'h3F;
  localparam logic [7:0] CH_STAR = 8'h2A;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic step;     // a text byte is consumed this cycle
    logic restart;  // active set returns to position zero
    logic clr;      // a new pattern starts: all slots but the written one become unused
  } cell_ctl_t;

endpackage

// ===== hw/rtl/gwm_cell.sv =====
// One pattern position of the glob matcher: pattern byte, slot-used bit, active bit.
// Depends on gwm_pkg for the control struct and the wildcard constants.
`timescale 1ns / 1ps

module gwm_cell
  import gwm_pkg::*;
#(
  parameter logic HEAD = 1'b0
) (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctl_t  ctl,
  input  logic       wr,
  input  logic [7:0] pat_byte,
  input  logic [7:0] text_byte,
  input  logic       closed,
  input  logic       fwd_in,
  output logic       act,
  output logic       star,
  output logic       fwd_out
);

  logic [7:0] pat;
  logic       used;
  logic       hit;
  logic       keep;

  assign star    = used && (pat == CH_STAR);
  assign hit     = used && ((pat == CH_STAR) || (pat == CH_ANY) || (pat == text_byte));
  assign keep    = ctl.step && closed && star;
  assign fwd_out = ctl.step && closed && hit;

  always_ff @(posedge clk) begin
    if (wr) begin
      pat <= pat_byte;
    end
  end

  // The head cell comes out of reset active, so matching starts at position zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      act  <= HEAD;
    end else begin
      if (wr) begin
        used <= 1'b1;
      end else if (ctl.clr) begin
        used <= 1'b0;
      end
      if (ctl.step || ctl.restart) begin
        act <= keep | fwd_in;
      end
    end
  end

endmodule

// ===== hw/rtl/glob_wildcard_matcher.sv =====
// Glob wildcard matcher ('*' and '?', case sensitive), top level.
// Pattern and text bytes are absorbed in the cycle they are accepted, and a finish item shows its
// result on the output register in the cycle after acceptance.
// Throughput is one item per cycle; only a finish result left waiting on a stalled output holds
// the input. The star closure is a single carry chain across the row of cells, which sets the clock.
// Reset clears the pattern length, the overflow flag and the output valid flag, and leaves only
// position zero active; pattern bytes are not cleared.
`timescale 1ns / 1ps

module glob_wildcard_matcher
  import gwm_pkg::*;
#(
  parameter int PAT_MAX = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [7:0] char_in,
  input  logic       first,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       matched,
  output logic       overflow
);

  localparam int LW = $clog2(PAT_MAX + 1);

  // Pattern length counts used slots, 0 to PAT_MAX.
  logic [LW-1:0]      length;
  logic [LW-1:0]      length_next;
  logic               ovf;
  logic               ovf_next;
  logic               act_end;

  logic               accept;
  logic               is_pat;
  logic               is_text;
  logic               is_finish;
  cell_ctl_t          ctl;

  logic [LW-1:0]      wr_idx;
  logic               wr_ok;

  logic [PAT_MAX-1:0] act_vec;
  logic [PAT_MAX-1:0] star_vec;
  logic [PAT_MAX-1:0] fwd_vec;
  logic [PAT_MAX-1:0] wr_vec;

  // Current active set (positions 0..PAT_MAX) before closure, and its closure.
  logic [PAT_MAX:0]   cur;
  logic [PAT_MAX:0]   add_a;
  logic [PAT_MAX:0]   add_b;
  logic [PAT_MAX:0]   add_sum;
  logic [PAT_MAX:0]   carry;
  logic [PAT_MAX:0]   closed;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    is_pat    = 1'b0;
    is_text   = 1'b0;
    is_finish = 1'b0;
    unique case (func_t'(func))
      FUNC_PATTERN: is_pat    = accept;
      FUNC_TEXT:    is_text   = accept;
      FUNC_FINISH:  is_finish = accept;
      default:      ;
    endcase
  end

  // A pattern byte or a finish puts the active set back to position zero; a text byte with
  // first set only replaces the set it starts from.
  assign ctl.step    = is_text;
  assign ctl.restart = is_pat || is_finish;
  assign ctl.clr     = is_pat && first;

  // Pattern loading. With first set the byte goes to slot zero and the flag is cleared.
  assign wr_idx = first ? '0 : length;
  assign wr_ok  = (wr_idx < LW'(PAT_MAX));

  always_comb begin
    length_next = length;
    ovf_next    = ovf;
    if (is_pat) begin
      if (first) begin
        ovf_next = 1'b0;
      end
      if (wr_ok) begin
        length_next = wr_idx + LW'(1);
      end else begin
        ovf_next = 1'b1;
      end
    end
  end

  // Star closure. A run of stars passes activity rightwards exactly like a carry: a star slot
  // propagates, and an active star slot generates. With A = star and B = star & active, the
  // carries of A + B are the bits that closure adds, so one adder covers any run length.
  assign cur     = (is_text && first) ? {{PAT_MAX{1'b0}}, 1'b1} : {act_end, act_vec};
  assign add_a   = {1'b0, star_vec};
  assign add_b   = {1'b0, star_vec & cur[PAT_MAX-1:0]};
  assign add_sum = add_a + add_b;
  assign carry   = add_sum ^ add_a ^ add_b;
  assign closed  = cur | carry;

  // The row of cells: each cell hands its forward match to its right neighbour every step.
  for (genvar i = 0; i < PAT_MAX; i++) begin : g_cell
    logic fwd_in;

    assign wr_vec[i] = is_pat && wr_ok && (wr_idx == LW'(i));

    if (i == 0) begin : g_head
      assign fwd_in = ctl.restart;
    end else begin : g_body
      assign fwd_in = fwd_vec[i-1];
    end

    gwm_cell #(
      .HEAD      (i == 0)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .wr        (wr_vec[i]),
      .pat_byte  (char_in),
      .text_byte (char_in),
      .closed    (closed[i]),
      .fwd_in    (fwd_in),
      .act       (act_vec[i]),
      .star      (star_vec[i]),
      .fwd_out   (fwd_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length  <= '0;
      ovf     <= 1'b0;
      act_end <= 1'b0;
    end else begin
      length <= length_next;
      ovf    <= ovf_next;
      // The position past the last slot only ever receives a forward match.
      if (ctl.step || ctl.restart) begin
        act_end <= fwd_vec[PAT_MAX-1];
      end
    end
  end

  // Output register: the finish result waits here until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_finish) begin
      matched  <= closed[length] && !ovf;
      overflow <= ovf;
    end
  end

endmodule
